// ===== hdl/iirs_pkg.sv =====
package iirs_pkg;

    localparam int MAX_DIM     = 64;
    localparam int POS_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = 2 * POS_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    localparam int DIM_W       = 7;
    localparam int PIX_W       = 8;
    localparam int FIELD_POS_W = 6;
    localparam int VAL_W       = 20;
    localparam int RUN_W       = 14;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RECT  = 2'd1,
        ST_NOT_READY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_FLAG
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        status_t            status;
        logic [ADDR_W-1:0]  addr_d;
        logic [ADDR_W-1:0]  addr_b;
        logic [ADDR_W-1:0]  addr_c;
        logic [ADDR_W-1:0]  addr_a;
        logic               use_b;
        logic               use_c;
        logic               use_a;
        logic [RUN_W-1:0]   run_sum;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LD_RD,
        BK_LD_WR,
        BK_Q_D,
        BK_Q_B,
        BK_Q_C,
        BK_Q_A,
        BK_Q_END
    } back_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

// ===== hdl/iirs_ram.sv =====
module iirs_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[addr] <= wdata;
        end
        if (en && !we) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/iirs_queue.sv =====
module iirs_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  iirs_pkg::cmd_t         push_cmd,
    input  logic                   pop,
    output iirs_pkg::cmd_t         head_cmd,
    output iirs_pkg::queue_status_t qstat
);

    iirs_pkg::cmd_t                  slot_reg [iirs_pkg::QUEUE_DEPTH];
    logic [iirs_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [iirs_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [iirs_pkg::QCNT_W-1:0]     count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == iirs_pkg::QPTR_W'(iirs_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + iirs_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == iirs_pkg::QPTR_W'(iirs_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + iirs_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + iirs_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - iirs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd    = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == iirs_pkg::QCNT_W'(iirs_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= iirs_pkg::QCNT_W'(iirs_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + iirs_pkg::QCNT_W'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

// ===== hdl/iirs_front.sv =====
module iirs_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iirs_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_valid,
    input  logic [iirs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirs_pkg::DIM_W-1:0]          cfg_data,
    input  iirs_pkg::queue_status_t             qstat,
    output logic                                push,
    output iirs_pkg::cmd_t                      push_cmd
);

    logic [iirs_pkg::DIM_W-1:0] width_reg, width_next;
    logic [iirs_pkg::DIM_W-1:0] height_reg, height_next;
    logic [iirs_pkg::POS_W-1:0] load_row_reg, load_row_next;
    logic [iirs_pkg::POS_W-1:0] load_col_reg, load_col_next;
    logic [iirs_pkg::RUN_W-1:0] run_reg, run_next;
    logic                       frame_done_reg, frame_done_next;

    logic [iirs_pkg::DIM_W-1:0]       w_eff, h_eff;
    logic [iirs_pkg::POS_W-1:0]       cur_row, cur_col;
    logic [iirs_pkg::RUN_W-1:0]       cur_run, new_run;
    logic                             col_last, row_last;
    logic [iirs_pkg::PIX_W-1:0]       pixel;
    logic [iirs_pkg::FIELD_POS_W-1:0] top_row, left_col;
    logic [iirs_pkg::DIM_W-1:0]       rect_rows, rect_cols;
    logic [iirs_pkg::DIM_W:0]         bot_end, right_end;
    logic                             rect_bad;
    logic [iirs_pkg::POS_W-1:0]       top_p, left_p, bot_p, right_p, above_p, before_p;

    assign pixel     = s_tdata[7:0];
    assign top_row   = s_tdata[13:8];
    assign left_col  = s_tdata[19:14];
    assign rect_rows = s_tdata[26:20];
    assign rect_cols = s_tdata[33:27];

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    assign w_eff = iirs_pkg::clamp_dim(width_reg);
    assign h_eff = iirs_pkg::clamp_dim(height_reg);

    assign cur_row = frame_done_reg ? '0 : load_row_reg;
    assign cur_col = frame_done_reg ? '0 : load_col_reg;
    assign cur_run = frame_done_reg ? '0 : run_reg;
    assign new_run = cur_run + iirs_pkg::RUN_W'(pixel);

    assign col_last = (iirs_pkg::DIM_W'(cur_col) + iirs_pkg::DIM_W'(1)) >= w_eff;
    assign row_last = (iirs_pkg::DIM_W'(cur_row) + iirs_pkg::DIM_W'(1)) >= h_eff;

    assign bot_end   = (iirs_pkg::DIM_W+1)'(top_row) + (iirs_pkg::DIM_W+1)'(rect_rows);
    assign right_end = (iirs_pkg::DIM_W+1)'(left_col) + (iirs_pkg::DIM_W+1)'(rect_cols);
    assign rect_bad  = (rect_rows == '0) || (rect_cols == '0) ||
                       (bot_end > (iirs_pkg::DIM_W+1)'(h_eff)) ||
                       (right_end > (iirs_pkg::DIM_W+1)'(w_eff));

    assign top_p    = iirs_pkg::POS_W'(top_row);
    assign left_p   = iirs_pkg::POS_W'(left_col);
    assign bot_p    = iirs_pkg::POS_W'(bot_end - (iirs_pkg::DIM_W+1)'(1));
    assign right_p  = iirs_pkg::POS_W'(right_end - (iirs_pkg::DIM_W+1)'(1));
    assign above_p  = top_p - iirs_pkg::POS_W'(1);
    assign before_p = left_p - iirs_pkg::POS_W'(1);

    always_comb begin
        push_cmd.kind    = iirs_pkg::CMD_LOAD;
        push_cmd.status  = iirs_pkg::ST_OK;
        push_cmd.addr_d  = {cur_row, cur_col};
        push_cmd.addr_b  = {cur_row - iirs_pkg::POS_W'(1), cur_col};
        push_cmd.addr_c  = '0;
        push_cmd.addr_a  = '0;
        push_cmd.use_b   = (cur_row != '0);
        push_cmd.use_c   = 1'b0;
        push_cmd.use_a   = 1'b0;
        push_cmd.run_sum = new_run;
        if (s_tuser == iirs_pkg::REQ_QUERY) begin
            push_cmd.addr_d = {bot_p, right_p};
            push_cmd.addr_b = {above_p, right_p};
            push_cmd.addr_c = {bot_p, before_p};
            push_cmd.addr_a = {above_p, before_p};
            push_cmd.use_b  = (top_p != '0);
            push_cmd.use_c  = (left_p != '0);
            push_cmd.use_a  = (top_p != '0) && (left_p != '0);
            if (!frame_done_reg) begin
                push_cmd.kind   = iirs_pkg::CMD_FLAG;
                push_cmd.status = iirs_pkg::ST_NOT_READY;
            end else if (rect_bad) begin
                push_cmd.kind   = iirs_pkg::CMD_FLAG;
                push_cmd.status = iirs_pkg::ST_BAD_RECT;
            end else begin
                push_cmd.kind   = iirs_pkg::CMD_QUERY;
            end
        end
    end

    always_comb begin
        width_next      = width_reg;
        height_next     = height_reg;
        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        run_next        = run_reg;
        frame_done_next = frame_done_reg;
        if (cfg_valid) begin
            if (cfg_index == iirs_pkg::CFG_IMAGE_WIDTH) begin
                width_next = cfg_data;
            end else begin
                height_next = cfg_data;
            end
            load_row_next   = '0;
            load_col_next   = '0;
            run_next        = '0;
            frame_done_next = 1'b0;
        end else if (push && s_tuser == iirs_pkg::REQ_LOAD) begin
            frame_done_next = 1'b0;
            if (col_last) begin
                load_col_next = '0;
                run_next      = '0;
                if (row_last) begin
                    load_row_next   = '0;
                    frame_done_next = 1'b1;
                end else begin
                    load_row_next = cur_row + iirs_pkg::POS_W'(1);
                end
            end else begin
                load_row_next = cur_row;
                load_col_next = cur_col + iirs_pkg::POS_W'(1);
                run_next      = new_run;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= iirs_pkg::DIM_W'(iirs_pkg::MAX_DIM);
            height_reg     <= iirs_pkg::DIM_W'(iirs_pkg::MAX_DIM);
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            run_reg        <= '0;
            frame_done_reg <= 1'b0;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            load_row_reg   <= load_row_next;
            load_col_reg   <= load_col_next;
            run_reg        <= run_next;
            frame_done_reg <= frame_done_next;
        end
    end

`ifndef ASSERT_OFF
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_done_reg |-> ((iirs_pkg::DIM_W'(load_col_reg) < w_eff) &&
                             (iirs_pkg::DIM_W'(load_row_reg) < h_eff)))
        else $error("load position outside frame");
`endif

endmodule

// ===== hdl/iirs_back.sv =====
module iirs_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  iirs_pkg::queue_status_t            qstat,
    input  iirs_pkg::cmd_t                     head_cmd,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [iirs_pkg::VAL_W-1:0]         m_value,
    output iirs_pkg::status_t                  m_status
);

    iirs_pkg::back_state_t             state_reg, state_next;
    iirs_pkg::cmd_t                    cmd_reg;
    logic [iirs_pkg::VAL_W-1:0]        acc_reg;
    logic                              m_tvalid_reg;
    logic [iirs_pkg::VAL_W-1:0]        value_reg;
    iirs_pkg::status_t                 status_reg;

    logic                              out_free;
    logic                              ram_en, ram_we;
    logic [iirs_pkg::ADDR_W-1:0]       ram_addr;
    logic [iirs_pkg::VAL_W-1:0]        ram_rdata;
    logic [iirs_pkg::VAL_W-1:0]        ld_val, q_val;

    assign out_free = !m_tvalid_reg || m_tready;
    assign ld_val   = (cmd_reg.use_b ? ram_rdata : '0) + iirs_pkg::VAL_W'(cmd_reg.run_sum);
    assign q_val    = acc_reg + (cmd_reg.use_a ? ram_rdata : '0);

    iirs_ram #(
        .WIDTH (iirs_pkg::VAL_W),
        .DEPTH (iirs_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ld_val),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iirs_pkg::BK_IDLE: begin
                if (pop) begin
                    case (head_cmd.kind)
                        iirs_pkg::CMD_LOAD:  state_next = iirs_pkg::BK_LD_RD;
                        iirs_pkg::CMD_QUERY: state_next = iirs_pkg::BK_Q_D;
                        default:             state_next = iirs_pkg::BK_IDLE;
                    endcase
                end
            end
            iirs_pkg::BK_LD_RD: state_next = iirs_pkg::BK_LD_WR;
            iirs_pkg::BK_LD_WR: begin
                if (out_free) begin
                    state_next = iirs_pkg::BK_IDLE;
                end
            end
            iirs_pkg::BK_Q_D: state_next = iirs_pkg::BK_Q_B;
            iirs_pkg::BK_Q_B: state_next = iirs_pkg::BK_Q_C;
            iirs_pkg::BK_Q_C: state_next = iirs_pkg::BK_Q_A;
            iirs_pkg::BK_Q_A: state_next = iirs_pkg::BK_Q_END;
            iirs_pkg::BK_Q_END: begin
                if (out_free) begin
                    state_next = iirs_pkg::BK_IDLE;
                end
            end
            default: state_next = iirs_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = cmd_reg.addr_d;
        case (state_reg)
            iirs_pkg::BK_IDLE: begin
                pop = !qstat.empty && (head_cmd.kind != iirs_pkg::CMD_FLAG || out_free);
            end
            iirs_pkg::BK_LD_RD: begin
                ram_en   = 1'b1;
                ram_addr = cmd_reg.addr_b;
            end
            iirs_pkg::BK_LD_WR: begin
                ram_en = out_free;
                ram_we = out_free;
            end
            iirs_pkg::BK_Q_D: begin
                ram_en = 1'b1;
            end
            iirs_pkg::BK_Q_B: begin
                ram_en   = 1'b1;
                ram_addr = cmd_reg.addr_b;
            end
            iirs_pkg::BK_Q_C: begin
                ram_en   = 1'b1;
                ram_addr = cmd_reg.addr_c;
            end
            iirs_pkg::BK_Q_A: begin
                ram_en   = 1'b1;
                ram_addr = cmd_reg.addr_a;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= iirs_pkg::BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == iirs_pkg::BK_IDLE && pop &&
                head_cmd.kind == iirs_pkg::CMD_FLAG) begin
                m_tvalid_reg <= 1'b1;
            end else if ((state_reg == iirs_pkg::BK_LD_WR ||
                          state_reg == iirs_pkg::BK_Q_END) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            iirs_pkg::BK_IDLE: begin
                if (pop) begin
                    cmd_reg <= head_cmd;
                    if (head_cmd.kind == iirs_pkg::CMD_FLAG) begin
                        value_reg  <= '0;
                        status_reg <= head_cmd.status;
                    end
                end
            end
            iirs_pkg::BK_LD_WR: begin
                if (out_free) begin
                    value_reg  <= ld_val;
                    status_reg <= iirs_pkg::ST_OK;
                end
            end
            iirs_pkg::BK_Q_B: acc_reg <= ram_rdata;
            iirs_pkg::BK_Q_C: acc_reg <= acc_reg - (cmd_reg.use_b ? ram_rdata : '0);
            iirs_pkg::BK_Q_A: acc_reg <= acc_reg - (cmd_reg.use_c ? ram_rdata : '0);
            iirs_pkg::BK_Q_END: begin
                if (out_free) begin
                    value_reg  <= q_val;
                    status_reg <= iirs_pkg::ST_OK;
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_value  = value_reg;
    assign m_status = status_reg;

`ifndef ASSERT_OFF
    a_write_is_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (cmd_reg.kind == iirs_pkg::CMD_LOAD))
        else $error("store written outside a load");

    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == iirs_pkg::BK_LD_WR || state_reg == iirs_pkg::BK_Q_END) && out_free)
        |=> (m_tvalid_reg && state_reg == iirs_pkg::BK_IDLE))
        else $error("finished item not presented");
`endif

endmodule

// ===== hdl/integral_image_rect_sum_top.sv =====
// Summed-area table over greyscale pixels in raster order. A beat with tuser low loads the
// next pixel and returns its integral value; tuser high is a rectangle query that returns
// the four-corner sum once a full frame has been loaded, otherwise status 2 (frame not
// complete) or status 1 (rectangle empty or out of frame) with value 0. Writing either
// image dimension restarts loading. A front end classifies beats and tracks the raster
// position, a two-entry queue decouples it from the back end, which owns the single-port
// store: a load does one read then one write, a valid query four reads, a flagged query
// none. Store contents are undefined until loaded; no clearing pass is run.
module integral_image_rect_sum_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel[7:0], top_row[13:8], left_col[19:14], rect_rows[26:20], rect_cols[33:27]
    input  logic [iirs_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // value[19:0]
    output logic [iirs_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [iirs_pkg::STATUS_W-1:0]       m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iirs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirs_pkg::DIM_W-1:0]          cfg_data
);

    iirs_pkg::queue_status_t        qstat;
    iirs_pkg::cmd_t                 push_cmd, head_cmd;
    logic                           push, pop;
    logic [iirs_pkg::VAL_W-1:0]     m_value;
    iirs_pkg::status_t              m_status;

    assign cfg_ready = 1'b1;

    iirs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    iirs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    iirs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_value),
        .m_status (m_status)
    );

    assign m_tdata = iirs_pkg::M_TDATA_W'(m_value);
    assign m_tuser = m_status;

endmodule
